// ===== sv/pwfd_pkg.sv =====
// Shared types, register codes and reset values for the pulse-width frame decoder.
// Depends on nothing; every other file of the block imports it.
package pwfd_pkg;

  localparam int TIME_W       = 64;
  localparam int PUB_W        = 40;
  localparam int COUNT_W      = 8;
  localparam int ERR_W        = 32;
  localparam int CODE_W       = 3;
  localparam int CFG_DATA_W   = 24;
  localparam int CFG_INDEX_W  = 3;
  localparam int FRAME_PULSES_DEF = 40;

  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SHORT_LIMIT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BIT_GAP     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_START_GAP   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_LIMIT = 3'd4;

  localparam logic [CODE_W-1:0] ERR_NONE       = 3'd0;
  localparam logic [CODE_W-1:0] ERR_OVERFLOW   = 3'd1;
  localparam logic [CODE_W-1:0] ERR_INCOMPLETE = 3'd2;
  localparam logic [CODE_W-1:0] ERR_BIT_GAP    = 3'd3;
  localparam logic [CODE_W-1:0] ERR_TIMEOUT    = 3'd4;

  localparam logic [15:0] DEBOUNCE_RST    = 16'd100;
  localparam logic [19:0] SHORT_LIMIT_RST = 20'd1500;
  localparam logic [19:0] BIT_GAP_RST     = 20'd5000;
  localparam logic [23:0] START_GAP_RST   = 24'd90000;
  localparam logic [23:0] FRAME_LIMIT_RST = 24'd200000;

  typedef struct packed {
    logic [15:0] debounce_time;
    logic [19:0] short_pulse_limit;
    logic [19:0] bit_gap_limit;
    logic [23:0] start_gap;
    logic [23:0] frame_time_limit;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0]  last_edge_time;
    logic [TIME_W-1:0]  frame_start_time;
    logic               frame_open;
    logic [COUNT_W-1:0] staging_count;
    logic [PUB_W-1:0]   published_bits;
    logic [ERR_W-1:0]   error_counter;
  } state_t;

  typedef struct packed {
    logic               valid;
    logic [PUB_W-1:0]   frame_bits;
    logic [COUNT_W-1:0] pulse_count;
    logic [CODE_W-1:0]  frame_status;
    logic [ERR_W-1:0]   error_total;
  } result_t;

endpackage

// ===== sv/pwfd_cfg_regs.sv =====
// Configuration register file of the pulse-width frame decoder.
// Depends on pwfd_pkg for the register codes, reset values and cfg_t.
module pwfd_cfg_regs
  import pwfd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_time     <= DEBOUNCE_RST;
      cfg.short_pulse_limit <= SHORT_LIMIT_RST;
      cfg.bit_gap_limit     <= BIT_GAP_RST;
      cfg.start_gap         <= START_GAP_RST;
      cfg.frame_time_limit  <= FRAME_LIMIT_RST;
    end else if (cfg_write) begin
      // mask to register width; unknown indexes drop the write
      unique case (cfg_index)
        REG_DEBOUNCE:    cfg.debounce_time     <= cfg_data[15:0];
        REG_SHORT_LIMIT: cfg.short_pulse_limit <= cfg_data[19:0];
        REG_BIT_GAP:     cfg.bit_gap_limit     <= cfg_data[19:0];
        REG_START_GAP:   cfg.start_gap         <= cfg_data[23:0];
        REG_FRAME_LIMIT: cfg.frame_time_limit  <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/pwfd_decode.sv =====
// Edge classifier: from one timestamp, the settings and the decoder state, forms
// the next state and the optional frame report. Depends on pwfd_pkg.
module pwfd_decode
  import pwfd_pkg::*;
#(
  parameter int FRAME_PULSES = FRAME_PULSES_DEF
) (
  input  cfg_t                    cfg,
  input  state_t                  st,
  input  logic [FRAME_PULSES-1:0] staging_bits,
  input  logic [TIME_W-1:0]       now,
  output state_t                  st_next,
  output logic [FRAME_PULSES-1:0] staging_bits_next,
  output result_t                 res
);

  localparam logic [COUNT_W-1:0] FP_COUNT  = COUNT_W'(FRAME_PULSES);
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  logic [TIME_W-1:0]  gap;
  logic [TIME_W-1:0]  age;
  logic [COUNT_W-1:0] idx;
  logic [PUB_W-1:0]   staged_pub;

  assign gap        = now - st.last_edge_time;
  assign age        = (st.frame_start_time != '0) ? now - st.frame_start_time : '0;
  assign idx        = st.staging_count;
  assign staged_pub = PUB_W'(staging_bits);

  always_comb begin
    st_next           = st;
    staging_bits_next = staging_bits;
    res.valid         = 1'b0;
    res.pulse_count   = idx;
    res.frame_status  = ERR_NONE;

    if (st.last_edge_time == '0) begin
      // first edge: record its time only
      st_next.last_edge_time = now;
    end else if (gap >= TIME_W'(cfg.debounce_time)) begin
      st_next.last_edge_time = now;
      if (gap >= TIME_W'(cfg.start_gap)) begin
        if (st.frame_open) begin
          res.valid = 1'b1;
          if (idx == FP_COUNT) begin
            st_next.published_bits = staged_pub;
            res.frame_status       = ERR_NONE;
          end else if (idx > FP_COUNT) begin
            res.frame_status      = ERR_OVERFLOW;
            st_next.error_counter = st.error_counter + 1'b1;
          end else begin
            res.frame_status      = ERR_INCOMPLETE;
            st_next.error_counter = st.error_counter + 1'b1;
          end
        end
        staging_bits_next        = '0;
        st_next.staging_count    = '0;
        st_next.frame_start_time = now;
        st_next.frame_open       = 1'b1;
      end else if (st.frame_open) begin
        if (gap > TIME_W'(cfg.bit_gap_limit)) begin
          res.valid             = 1'b1;
          res.frame_status      = ERR_BIT_GAP;
          st_next.frame_open    = 1'b0;
          st_next.error_counter = st.error_counter + 1'b1;
        end else if (age > TIME_W'(cfg.frame_time_limit)) begin
          res.valid             = 1'b1;
          res.frame_status      = ERR_TIMEOUT;
          st_next.frame_open    = 1'b0;
          st_next.error_counter = st.error_counter + 1'b1;
        end else begin
          // store a short pulse as one; pulses past the frame length are only counted
          if (gap < TIME_W'(cfg.short_pulse_limit) && idx < FP_COUNT) begin
            staging_bits_next = staging_bits |
                                (FRAME_PULSES'(1) << idx[$clog2(FRAME_PULSES+1)-1:0]);
          end
          if (idx != COUNT_MAX) begin
            st_next.staging_count = idx + 1'b1;
          end
        end
      end
    end

    res.frame_bits  = st_next.published_bits;
    res.error_total = st_next.error_counter;
  end

endmodule

// ===== sv/pulse_width_frame_decoder_core.sv =====
// Pulse-width frame decoder: each beat on the input channel carries the microsecond
// timestamp of one falling edge. One beat is accepted every cycle while ready is high;
// its report, if any, passes through the input register, then the result register.
// While the result register is full, silent edges still pass through; a beat that
// reports waits in the input register and holds ready low until the result register frees.
// The per-edge path is the 64-bit gap and frame-age subtracts, side by side, with their
// threshold compares. Configuration writes take effect at once and belong in idle periods.
// Depends on pwfd_pkg, pwfd_cfg_regs and pwfd_decode.
module pulse_width_frame_decoder_core
  import pwfd_pkg::*;
#(
  parameter int FRAME_PULSES = FRAME_PULSES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [TIME_W-1:0]      edge_time,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [PUB_W-1:0]       frame_bits,
  output logic [COUNT_W-1:0]     pulse_count,
  output logic [CODE_W-1:0]      frame_status,
  output logic [ERR_W-1:0]       error_total
);

  cfg_t                    cfg;
  state_t                  st;
  state_t                  st_next;
  logic [FRAME_PULSES-1:0] staging_bits;
  logic [FRAME_PULSES-1:0] staging_bits_next;
  result_t                 res;

  logic              s1_valid;
  logic [TIME_W-1:0] s1_time;
  logic              out_free;
  logic              s1_go;

  pwfd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pwfd_decode #(
    .FRAME_PULSES (FRAME_PULSES)
  ) u_decode (
    .cfg               (cfg),
    .st                (st),
    .staging_bits      (staging_bits),
    .now               (s1_time),
    .st_next           (st_next),
    .staging_bits_next (staging_bits_next),
    .res               (res)
  );

  assign out_free = !out_valid || out_ready;
  // advance unless a report is due and the result register is still full
  assign s1_go    = s1_valid && (!res.valid || out_free);
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_time <= edge_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= '0;
      staging_bits <= '0;
    end else if (s1_go) begin
      st           <= st_next;
      staging_bits <= staging_bits_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res.valid) begin
      frame_bits   <= res.frame_bits;
      pulse_count  <= res.pulse_count;
      frame_status <= res.frame_status;
      error_total  <= res.error_total;
    end
  end

`ifndef ASSERT_OFF
  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && out_valid)
    else $error("input stalled while a stage is empty");

  a_complete_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_status == ERR_NONE |-> pulse_count == COUNT_W'(FRAME_PULSES))
    else $error("complete frame with wrong pulse count");

  a_overflow_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_status == ERR_OVERFLOW |-> pulse_count > COUNT_W'(FRAME_PULSES))
    else $error("overflow report without excess pulses");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> frame_status <= ERR_TIMEOUT)
    else $error("undefined error code reported");
`endif

endmodule

// ===== tb/tb_pwfd_sb_pkg.sv =====
`timescale 1ns / 100ps
// Frame report scoreboard for the pulse-width frame decoder bench: predicts the
// report that each accepted edge produces and checks the reports that come out.
// Depends on pwfd_pkg.
package tb_pwfd_sb_pkg;
  import pwfd_pkg::*;

  localparam int FRAME_LEN = FRAME_PULSES_DEF;

  typedef struct packed {
    logic [PUB_W-1:0]   frame_bits;
    logic [COUNT_W-1:0] pulse_count;
    logic [CODE_W-1:0]  frame_status;
    logic [ERR_W-1:0]   error_total;
  } frame_report_t;

  class frame_scoreboard;
    cfg_t               regs;
    logic [TIME_W-1:0]  last_edge;
    logic [TIME_W-1:0]  frame_start;
    logic               frame_open;
    logic [PUB_W-1:0]   staging_bits;
    logic [COUNT_W-1:0] staging_count;
    logic [PUB_W-1:0]   published_bits;
    logic [ERR_W-1:0]   error_total;
    frame_report_t      reports_due[$];
    int unsigned        mismatches;
    int unsigned        reports_seen;

    function new();
      regs.debounce_time     = DEBOUNCE_RST;
      regs.short_pulse_limit = SHORT_LIMIT_RST;
      regs.bit_gap_limit     = BIT_GAP_RST;
      regs.start_gap         = START_GAP_RST;
      regs.frame_time_limit  = FRAME_LIMIT_RST;
      last_edge      = '0;
      frame_start    = '0;
      frame_open     = 1'b0;
      staging_bits   = '0;
      staging_count  = '0;
      published_bits = '0;
      error_total    = '0;
      mismatches     = 0;
      reports_seen   = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_DEBOUNCE:    regs.debounce_time     = data[15:0];
        REG_SHORT_LIMIT: regs.short_pulse_limit = data[19:0];
        REG_BIT_GAP:     regs.bit_gap_limit     = data[19:0];
        REG_START_GAP:   regs.start_gap         = data;
        REG_FRAME_LIMIT: regs.frame_time_limit  = data;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return reports_due.size();
    endfunction

    function void post_report(logic [COUNT_W-1:0] count, logic [CODE_W-1:0] code);
      frame_report_t rpt;
      rpt.frame_bits   = published_bits;
      rpt.pulse_count  = count;
      rpt.frame_status = code;
      rpt.error_total  = error_total;
      reports_due.push_back(rpt);
    endfunction

    function void note_edge(logic [TIME_W-1:0] now_us);
      logic [TIME_W-1:0]  gap;
      logic [TIME_W-1:0]  age;
      logic [COUNT_W-1:0] idx;
      // a zero stamp on the first edge leaves the decoder waiting again
      if (last_edge == '0) begin
        last_edge = now_us;
        return;
      end
      gap = now_us - last_edge;
      if (gap < regs.debounce_time) return;
      last_edge = now_us;
      age = (frame_start != '0) ? now_us - frame_start : '0;
      idx = staging_count;

      if (gap >= regs.start_gap) begin
        if (frame_open) begin
          if (idx == FRAME_LEN) begin
            published_bits = staging_bits;
            post_report(idx, ERR_NONE);
          end else begin
            error_total++;
            post_report(idx, (idx > FRAME_LEN) ? ERR_OVERFLOW : ERR_INCOMPLETE);
          end
        end
        staging_bits  = '0;
        staging_count = '0;
        frame_start   = now_us;
        frame_open    = 1'b1;
        return;
      end

      if (!frame_open) return;
      if (gap > regs.bit_gap_limit || age > regs.frame_time_limit) begin
        frame_open = 1'b0;
        error_total++;
        post_report(idx, (gap > regs.bit_gap_limit) ? ERR_BIT_GAP : ERR_TIMEOUT);
        return;
      end
      // count past the frame length but store only what fits; saturate the count
      if (gap < regs.short_pulse_limit && idx < FRAME_LEN) staging_bits[idx] = 1'b1;
      if (idx != '1) staging_count = idx + 1'b1;
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      $display("%0t: %s mismatch, got 'h%0h, expected 'h%0h", $time, what, got, want);
    endtask

    task check_report(frame_report_t got);
      frame_report_t want;
      reports_seen++;
      if (reports_due.size() == 0) begin
        report_mismatch("unexpected report", 64'(got.pulse_count), '0);
        return;
      end
      want = reports_due.pop_front();
      if (got.frame_bits !== want.frame_bits)
        report_mismatch("frame_bits", 64'(got.frame_bits), 64'(want.frame_bits));
      if (got.pulse_count !== want.pulse_count)
        report_mismatch("pulse_count", 64'(got.pulse_count), 64'(want.pulse_count));
      if (got.frame_status !== want.frame_status)
        report_mismatch("frame_status", 64'(got.frame_status), 64'(want.frame_status));
      if (got.error_total !== want.error_total)
        report_mismatch("error_total", 64'(got.error_total), 64'(want.error_total));
    endtask
  endclass

endpackage

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Top-level bench for pulse_width_frame_decoder_core: sends timestamped edge beats,
// writes the timing registers between phases and checks every frame report beat.
// Depends on pwfd_pkg, tb_pwfd_sb_pkg and the decoder RTL.
module tb_top;
  import pwfd_pkg::*;
  import tb_pwfd_sb_pkg::*;

  localparam int ITEM_TARGET     = 700;
  localparam int REPORT_TARGET   = 60;
  localparam int SETTLE_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int HOLD_OFF_CYCLES = 400;

  typedef enum logic [2:0] {GAP_ONE, GAP_ZERO, GAP_BOUNCE, GAP_START, GAP_BREAK} gap_kind_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_DEBOUNCE;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [TIME_W-1:0]      edge_time = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [PUB_W-1:0]       frame_bits;
  logic [COUNT_W-1:0]     pulse_count;
  logic [CODE_W-1:0]      frame_status;
  logic [ERR_W-1:0]       error_total;

  frame_scoreboard   sb = new();
  logic [TIME_W-1:0] stamp_now = '0;
  int unsigned       edges_sent = 0;
  int                hold_off = 0;
  bit                steady = 1'b0;

  pulse_width_frame_decoder_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .edge_time    (edge_time),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame_bits   (frame_bits),
    .pulse_count  (pulse_count),
    .frame_status (frame_status),
    .error_total  (error_total)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin : monitor
    frame_report_t seen;
    if (!rst && in_valid && in_ready) sb.note_edge(edge_time);
    if (!rst && out_valid && out_ready) begin
      seen = {frame_bits, pulse_count, frame_status, error_total};
      sb.check_report(seen);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // mostly no gap, some short ones, a few long ones
  function automatic int idle_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin : receiver
    int n;
    forever begin
      if (hold_off > 0) begin
        n = hold_off;
        hold_off = 0;
        out_ready <= 1'b0;
      end else if (steady || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 16);
      end else begin
        out_ready <= 1'b0;
        n = idle_len();
        if (n == 0) n = 1;
      end
      repeat (n) @(posedge clk);
    end
  end

  function automatic longint unsigned pick_span(longint unsigned lo, longint unsigned hi);
    if (hi <= lo) return lo;
    return lo + $urandom_range(0, 32'(hi - lo));
  endfunction

  // gap in us that lands in the wanted class under the current register values
  function automatic longint unsigned gap_for(gap_kind_t kind);
    longint unsigned deb;
    longint unsigned one_top;
    longint unsigned gap_top;
    longint unsigned start;
    deb     = 64'(sb.regs.debounce_time);
    one_top = 64'(sb.regs.short_pulse_limit);
    gap_top = 64'(sb.regs.bit_gap_limit);
    start   = (64'(sb.regs.start_gap) > deb) ? 64'(sb.regs.start_gap) : deb;
    case (kind)
      GAP_ONE:    return (one_top > deb) ? pick_span(deb, one_top - 1) : deb;
      GAP_ZERO:   return pick_span((one_top > deb) ? one_top : deb, gap_top);
      GAP_BOUNCE: return (deb > 0) ? pick_span(0, deb - 1) : 0;
      GAP_START:  return ($urandom_range(0, 3) == 0) ? start : pick_span(start, start + 50);
      default:    return pick_span(gap_top + 1, (start > gap_top + 1) ? start - 1 : gap_top + 1);
    endcase
  endfunction

  // keep valid high across back-to-back beats; drop it only for a gap
  task automatic send_edge(input logic [TIME_W-1:0] stamp);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    edge_time <= stamp;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_at(input logic [TIME_W-1:0] stamp);
    stamp_now = stamp;
    send_edge(stamp);
    edges_sent++;
  endtask

  task automatic tick(input longint unsigned gap, input bit counted);
    stamp_now += gap;
    send_edge(stamp_now);
    if (counted) edges_sent++;
  endtask

  task automatic send_frame(input int pulses, input bit rough, input bit zero_start);
    int r;
    r = $urandom_range(0, 99);
    if (rough && r < 12) send_at({$urandom, $urandom});
    else if (rough && r < 24) stamp_now = '0 - pick_span(0, 300000);
    if (zero_start) send_at('0);
    else tick(gap_for(GAP_START), 1'b1);
    for (int i = 0; i < pulses; i++) begin
      r = $urandom_range(0, 99);
      if (rough && r < 6) tick(gap_for(GAP_BOUNCE), 1'b0);
      else if (rough && r < 9) tick(gap_for(GAP_BREAK), 1'b1);
      tick(gap_for($urandom_range(0, 1) ? GAP_ONE : GAP_ZERO), 1'b1);
    end
  endtask

  // wait until every report is in and the pipeline has flushed silent edges
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  // upper bits beyond the debounce, short-limit and bit-gap widths carry junk that must be dropped
  task automatic program_regs(input logic [CFG_DATA_W-1:0] deb, input logic [CFG_DATA_W-1:0] one_lim,
                              input logic [CFG_DATA_W-1:0] gap_lim, input logic [CFG_DATA_W-1:0] start,
                              input logic [CFG_DATA_W-1:0] frame_lim);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(REG_DEBOUNCE, {junk[7:0], deb[15:0]});
    write_reg(REG_SHORT_LIMIT, {junk[11:8], one_lim[19:0]});
    write_reg(REG_BIT_GAP, {junk[15:12], gap_lim[19:0]});
    write_reg(REG_START_GAP, start);
    write_reg(REG_FRAME_LIMIT, frame_lim);
    write_reg(CFG_INDEX_W'(REG_FRAME_LIMIT + $urandom_range(1, 3)), junk[31:8]);
    cfg_write <= 1'b0;
  endtask

  task automatic program_random();
    logic [CFG_DATA_W-1:0] deb;
    logic [CFG_DATA_W-1:0] one_lim;
    logic [CFG_DATA_W-1:0] gap_lim;
    logic [CFG_DATA_W-1:0] start;
    logic [CFG_DATA_W-1:0] frame_lim;
    deb     = CFG_DATA_W'($urandom_range(0, 300));
    one_lim = CFG_DATA_W'(deb + $urandom_range(1, 2000));
    gap_lim = CFG_DATA_W'(one_lim + $urandom_range(0, 4000));
    start   = CFG_DATA_W'(gap_lim + $urandom_range(1, 200000));
    if ($urandom_range(0, 3) == 0) frame_lim = CFG_DATA_W'($urandom_range(0, 60000));
    else frame_lim = CFG_DATA_W'($urandom_range(100000, 16777215));
    program_regs(deb, one_lim, gap_lim, start, frame_lim);
  endtask

  initial begin : stimulus
    logic [TIME_W-1:0] script[$];
    int frames;
    int r;
    int pulses;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values: unset first edge, bounce, edges outside a frame, bit class
    // boundaries, bit boundary abort, incomplete frame, wrap past all ones,
    // and a frame that opens at time zero
    script = '{64'd0, 64'd1000, 64'd1050, 64'd6000, 64'd96000, 64'd97499, 64'd98999,
               64'd103999, 64'd109000, 64'd199000, 64'd199100, 64'd289100, '1,
               64'd0, 64'd1499, 64'd0, 64'd1000};
    foreach (script[i]) send_at(script[i]);
    settle();

    // hold the receiver while frame-closing edges pile up behind it
    hold_off = HOLD_OFF_CYCLES;
    wait (hold_off == 0);
    steady = 1'b1;
    for (int i = 0; i < 30; i++) tick(gap_for(GAP_START), 1'b1);
    steady = 1'b0;
    settle();

    program_regs('0, '1, '1, '1, '1);
    for (int i = 0; i < 4; i++) send_frame(FRAME_LEN, 1'b0, 1'b0);
    settle();
    program_regs('1, '0, '0, '0, '0);
    send_frame(20, 1'b1, 1'b0);
    settle();

    // zero frame age limit: only the frame opened at time zero survives
    program_regs(CFG_DATA_W'(DEBOUNCE_RST), CFG_DATA_W'(SHORT_LIMIT_RST),
                 CFG_DATA_W'(BIT_GAP_RST), START_GAP_RST, '0);
    send_frame(6, 1'b0, 1'b1);
    send_frame(6, 1'b0, 1'b0);
    send_frame(0, 1'b0, 1'b0);
    settle();

    // pulse count saturation and overflow, then a clean frame
    program_regs(24'd10, 24'd50, 24'd200, 24'd5000, '1);
    send_frame(260, 1'b0, 1'b0);
    send_frame(FRAME_LEN, 1'b0, 1'b0);
    send_frame(0, 1'b0, 1'b0);
    settle();

    program_regs(CFG_DATA_W'(DEBOUNCE_RST), CFG_DATA_W'(SHORT_LIMIT_RST),
                 CFG_DATA_W'(BIT_GAP_RST), START_GAP_RST, FRAME_LIMIT_RST);
    frames = 0;
    while (edges_sent < ITEM_TARGET || sb.reports_seen < REPORT_TARGET) begin
      if (frames % 8 == 7) begin
        settle();
        program_random();
      end
      steady = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 50) pulses = FRAME_LEN;
      else if (r < 75) pulses = $urandom_range(0, FRAME_LEN - 1);
      else if (r < 85) pulses = $urandom_range(FRAME_LEN + 1, FRAME_LEN + 8);
      else pulses = $urandom_range(0, 60);
      send_frame(pulses, $urandom_range(0, 3) == 0, $urandom_range(0, 24) == 0);
      frames++;
    end
    steady = 1'b0;
    settle();

    if (sb.pending() != 0) sb.report_mismatch("missing reports", 64'(sb.pending()), '0);
    if (sb.mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
